>>> hdl/salc_pkg.sv
// Shared constants for the set-associative LRU cache tag model.
// Depends on nothing; imported by set_assoc_lru_cache_model.
`default_nettype none

package salc_pkg;

  // Fixed field widths
  localparam int ADDR_W   = 64;
  localparam int CNT_W    = 32;
  localparam int OFFSET_W = 4;

  // Reset value of the block offset register
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(4);

  // Parameter defaults
  localparam int SET_BITS_DEF = 2;
  localparam int WAYS_DEF     = 4;
  localparam int STAMP_W_DEF  = 32;

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

>>> hdl/set_assoc_lru_cache_model.sv
// Set-associative cache tag model with LRU replacement and running totals.
// Depends on salc_pkg for field widths, reset values and parameter defaults.
//
// One access is accepted on every cycle that start is high: busy is never
// raised. The access is held in an input register while the
// tag compare, LRU victim pick, line update and counter update run in a
// single combinational pass. The result lands in the output register at the
// clock edge after the accepting edge, so out_strobe is high for the
// one cycle that follows that edge.
// The sustained rate is one access per cycle, with each access seeing the
// line state left by the one before it. The result cannot be stalled:
// the receiver must take it in the cycle that out_strobe is high.
`default_nettype none

module set_assoc_lru_cache_model #(
  parameter int SET_BITS = salc_pkg::SET_BITS_DEF,
  parameter int WAYS     = salc_pkg::WAYS_DEF,
  parameter int STAMP_W  = salc_pkg::STAMP_W_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // access channel
  input  wire                                start,
  output logic                               busy,
  input  wire  [salc_pkg::ADDR_W-1:0]        in_address,
  input  wire                                in_modify,
  // result channel
  output logic                               out_strobe,
  output logic                               out_was_hit,
  output logic                               out_was_eviction,
  output logic                               out_repeat_hit,
  output logic [salc_pkg::CNT_W-1:0]         out_hit_total,
  output logic [salc_pkg::CNT_W-1:0]         out_miss_total,
  output logic [salc_pkg::CNT_W-1:0]         out_eviction_total,
  // configuration
  input  wire                                cfg_we,
  input  wire  [salc_pkg::OFFSET_W-1:0]      cfg_wdata
);
  import salc_pkg::*;

  localparam int SETS   = 1 << SET_BITS;
  localparam int SET_IW = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W  = ADDR_W - SET_BITS;
  localparam int SH_W   = 7;
  localparam logic [SET_IW-1:0] SET_MASK = SET_IW'(SETS - 1);

  // Configuration
  logic [OFFSET_W-1:0] offset_r;

  // Input register
  logic              in_valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic              modify_r;

  // Line state
  logic               valid_r [SETS][WAYS];
  logic [TAG_W-1:0]   tag_r   [SETS][WAYS];
  logic [STAMP_W-1:0] stamp_r [SETS][WAYS];
  logic [STAMP_W-1:0] time_r;

  // Running totals
  cnt_t hits_r, misses_r, evicts_r;

  // Output register
  logic out_strobe_r, out_hit_r, out_evict_r, out_repeat_r;
  cnt_t out_hits_r, out_misses_r, out_evicts_r;

  // Combinational pass
  logic [ADDR_W-1:0]  set_shift;
  logic [ADDR_W-1:0]  tag_shift;
  logic [SH_W-1:0]    tag_sh;
  logic [SET_IW-1:0]  set_idx;
  logic [TAG_W-1:0]   tag;
  logic [STAMP_W-1:0] stamp_nxt;
  logic               hit;
  logic [WAY_IW-1:0]  hit_way;
  logic               have_inv;
  logic               have_val;
  logic [STAMP_W-1:0] oldest;
  logic [WAY_IW-1:0]  victim;
  logic               evict;
  logic [WAY_IW-1:0]  upd_way;
  logic [1:0]         hit_inc;
  logic [CNT_W:0]     hits_sum, misses_sum, evicts_sum;
  cnt_t               hits_nxt, misses_nxt, evicts_nxt;

  assign busy = 1'b0;

  // Split the address into set index and tag
  always_comb begin
    set_shift = addr_r >> offset_r;
    set_idx   = set_shift[SET_IW-1:0] & SET_MASK;
    tag_sh    = SH_W'(offset_r) + SH_W'(SET_BITS);
    tag_shift = addr_r >> tag_sh;
    tag       = tag_shift[TAG_W-1:0];
    stamp_nxt = time_r + STAMP_W'(1);
  end

  // Compare the tag against every way of the set
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid_r[set_idx][w] && tag_r[set_idx][w] == tag) begin
        hit     = 1'b1;
        hit_way = WAY_IW'(w);
      end
    end
  end

  // Pick the victim: lowest invalid way, else oldest stamp, lowest way on a tie
  always_comb begin
    have_inv = 1'b0;
    have_val = 1'b0;
    oldest   = '0;
    victim   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!valid_r[set_idx][w]) begin
        if (!have_inv) begin
          have_inv = 1'b1;
          victim   = WAY_IW'(w);
        end
      end else if (!have_inv) begin
        if (!have_val || stamp_r[set_idx][w] < oldest) begin
          have_val = 1'b1;
          oldest   = stamp_r[set_idx][w];
          victim   = WAY_IW'(w);
        end
      end
    end
    evict   = !hit && !have_inv;
    upd_way = hit ? hit_way : victim;
  end

  // Saturating totals; a modify adds one more hit for the repeat
  always_comb begin
    hit_inc    = {1'b0, hit} + {1'b0, modify_r};
    hits_sum   = {1'b0, hits_r} + (CNT_W + 1)'(hit_inc);
    misses_sum = {1'b0, misses_r} + (CNT_W + 1)'(!hit);
    evicts_sum = {1'b0, evicts_r} + (CNT_W + 1)'(evict);
    hits_nxt   = hits_sum[CNT_W]   ? '1 : hits_sum[CNT_W-1:0];
    misses_nxt = misses_sum[CNT_W] ? '1 : misses_sum[CNT_W-1:0];
    evicts_nxt = evicts_sum[CNT_W] ? '1 : evicts_sum[CNT_W-1:0];
  end

  // Control state: config, input valid, valid bits, time, totals, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= OFFSET_RESET;
      in_valid_r   <= 1'b0;
      time_r       <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
      out_strobe_r <= 1'b0;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          valid_r[s][w] <= 1'b0;
        end
      end
    end else begin
      if (cfg_we) begin
        offset_r <= cfg_wdata;
      end
      in_valid_r   <= start;
      out_strobe_r <= in_valid_r;
      if (in_valid_r) begin
        time_r                   <= stamp_nxt;
        hits_r                   <= hits_nxt;
        misses_r                 <= misses_nxt;
        evicts_r                 <= evicts_nxt;
        valid_r[set_idx][upd_way] <= 1'b1;
      end
    end
  end

  // Payload: input capture, line tag and stamp, result register
  always_ff @(posedge clk) begin
    if (start) begin
      addr_r   <= in_address;
      modify_r <= in_modify;
    end
    if (in_valid_r) begin
      tag_r[set_idx][upd_way]   <= tag;
      stamp_r[set_idx][upd_way] <= stamp_nxt;
      out_hit_r    <= hit;
      out_evict_r  <= evict;
      out_repeat_r <= modify_r;
      out_hits_r   <= hits_nxt;
      out_misses_r <= misses_nxt;
      out_evicts_r <= evicts_nxt;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_was_hit        = out_hit_r;
  assign out_was_eviction   = out_evict_r;
  assign out_repeat_hit     = out_repeat_r;
  assign out_hit_total      = out_hits_r;
  assign out_miss_total     = out_misses_r;
  assign out_eviction_total = out_evicts_r;

endmodule

`default_nettype wire

>>> sim/tb_set_assoc_lru_cache_model.sv
// Self-checking testbench for the set-associative LRU cache tag model.
// Depends on salc_pkg and set_assoc_lru_cache_model; predicts each result
// from a shadow copy of the tag store and compares every transaction.
`default_nettype none

module tb_set_assoc_lru_cache_model;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int NUM_SETS      = 1 << SET_BITS_DEF;
  localparam int NUM_WAYS      = WAYS_DEF;
  localparam int NUM_LINES     = NUM_SETS * NUM_WAYS;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int POOL_SIZE     = 6;

  typedef struct packed {
    logic was_hit;
    logic was_eviction;
    logic repeat_hit;
    cnt_t hit_total;
    cnt_t miss_total;
    cnt_t eviction_total;
  } access_result_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                start       = 1'b0;
  logic [ADDR_W-1:0]   in_address  = '0;
  logic                in_modify   = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [OFFSET_W-1:0] cfg_wdata   = '0;
  logic                busy;
  logic                out_strobe;
  logic                out_was_hit;
  logic                out_was_eviction;
  logic                out_repeat_hit;
  cnt_t                out_hit_total;
  cnt_t                out_miss_total;
  cnt_t                out_eviction_total;

  // Shadow tag store and counters
  logic                   line_present [NUM_LINES];
  logic [ADDR_W-1:0]      line_tag_copy[NUM_LINES];
  logic [STAMP_W_DEF-1:0] line_use_time[NUM_LINES];
  logic [STAMP_W_DEF-1:0] use_clock;
  cnt_t                   shadow_hits;
  cnt_t                   shadow_misses;
  cnt_t                   evict_count;
  logic [OFFSET_W-1:0]    offset_setting;

  access_result_t pending_results[$];
  int             error_count = 0;
  int             quiet_cycles = 0;

  always #4 clk = ~clk;

  set_assoc_lru_cache_model u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_address        (in_address),
    .in_modify         (in_modify),
    .out_strobe        (out_strobe),
    .out_was_hit       (out_was_hit),
    .out_was_eviction  (out_was_eviction),
    .out_repeat_hit    (out_repeat_hit),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .out_eviction_total(out_eviction_total),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  function automatic cnt_t bump_count(input cnt_t value);
    return (value == '1) ? value : value + 1'b1;
  endfunction

  // Look up one line in the shadow store; on a miss fill an invalid or the LRU way
  function automatic logic lookup_line(input logic [ADDR_W-1:0] addr, output logic evicted);
    int unsigned            set_idx;
    int unsigned            base;
    int unsigned            victim;
    int unsigned            idx;
    logic [ADDR_W-1:0]      tag;
    logic                   have_invalid;
    logic                   have_valid;
    logic [STAMP_W_DEF-1:0] oldest;
    evicted      = 1'b0;
    set_idx      = 32'((addr >> offset_setting) & 64'(NUM_SETS - 1));
    tag          = addr >> (offset_setting + SET_BITS_DEF);
    base         = set_idx * NUM_WAYS;
    victim       = 0;
    have_invalid = 1'b0;
    have_valid   = 1'b0;
    oldest       = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (line_present[base + w] && line_tag_copy[base + w] == tag) begin
        shadow_hits = bump_count(shadow_hits);
        line_use_time[base + w] = use_clock;
        return 1'b1;
      end
    end
    shadow_misses = bump_count(shadow_misses);
    // Lowest invalid way first, else the smallest stamp, lowest way on a tie
    for (int w = 0; w < NUM_WAYS; w++) begin
      idx = base + w;
      if (!line_present[idx]) begin
        if (!have_invalid) begin
          have_invalid = 1'b1;
          victim       = w;
        end
      end else if (!have_invalid) begin
        if (!have_valid || line_use_time[idx] < oldest) begin
          have_valid = 1'b1;
          oldest     = line_use_time[idx];
          victim     = w;
        end
      end
    end
    if (line_present[base + victim]) begin
      evict_count = bump_count(evict_count);
      evicted     = 1'b1;
    end
    line_present[base + victim]  = 1'b1;
    line_tag_copy[base + victim] = tag;
    line_use_time[base + victim] = use_clock;
    return 1'b0;
  endfunction

  // Advance the use clock and work out the result of one access
  function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr,
                                                    input logic modify);
    access_result_t res;
    logic           evicted;
    logic           ignored;
    use_clock        = use_clock + 1'b1;
    res.was_hit      = lookup_line(addr, evicted);
    res.was_eviction = evicted;
    if (modify) begin
      void'(lookup_line(addr, ignored));
    end
    res.repeat_hit     = modify;
    res.hit_total      = shadow_hits;
    res.miss_total     = shadow_misses;
    res.eviction_total = evict_count;
    return res;
  endfunction

  // Send one access transaction; optionally go idle afterwards
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic modify,
                             input int idle_pct);
    int gap;
    start      <= 1'b1;
    in_address <= addr;
    in_modify  <= modify;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_access(addr, modify));
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      start      <= 1'b0;
      in_address <= {$urandom, $urandom};
      in_modify  <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    offset_setting = value;
  endtask

  // Fill a set, hit, evict in LRU order, modify on hit and on miss
  task automatic test_fill_and_evict();
    send_access(64'h0, 1'b0, 0);
    send_access(64'h0, 1'b0, 0);
    send_access('1, 1'b1, 0);
    send_access(64'h40, 1'b0, 0);
    send_access(64'h80, 1'b1, 0);
    send_access(64'hC0, 1'b0, 0);
    send_access(64'h100, 1'b0, 0);
    send_access(64'h40, 1'b1, 0);
    send_access(64'h0, 1'b0, 0);
    send_access(64'h80, 1'b0, 0);
    send_access(64'h8000_0000_0000_001F, 1'b1, 0);
  endtask

  // Change the split mid-run at both ends and above the nominal range
  task automatic test_offset_extremes();
    drain_results();
    write_offset(4'd0);
    send_access(64'h0, 1'b0, 0);
    send_access(64'h1, 1'b1, 0);
    send_access(64'h4, 1'b0, 0);
    send_access('1, 1'b0, 0);
    drain_results();
    write_offset(4'd15);
    send_access(64'h0, 1'b0, 0);
    send_access(64'h8000, 1'b1, 0);
    send_access(64'h2_0000, 1'b0, 0);
    send_access(64'hFFFF_FFFF_FFFF_7FFF, 1'b1, 0);
    drain_results();
    write_offset(4'd12);
    send_access(64'h1000, 1'b0, 0);
    send_access(64'h3000, 1'b1, 0);
    send_access(64'h4000, 1'b0, 0);
    send_access(64'h1234_5678_9ABC_DEF0, 1'b0, 0);
  endtask

  // Traffic over a small tag pool shared by all sets, with some wide-open addresses
  task automatic test_random_traffic(input logic [OFFSET_W-1:0] offset, input int idle_pct,
                                     input int count);
    logic [ADDR_W-1:0] tag_pool[POOL_SIZE];
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] low_mask;
    drain_results();
    write_offset(offset);
    foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
    low_mask = (64'd1 << offset) - 1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) begin
        addr = (tag_pool[$urandom_range(POOL_SIZE - 1)] << (offset + SET_BITS_DEF))
             | (64'($urandom_range(NUM_SETS - 1)) << offset)
             | ({$urandom, $urandom} & low_mask);
      end else begin
        addr = {$urandom, $urandom};
      end
      send_access(addr, 1'($urandom_range(1)), idle_pct);
      if ($urandom_range(59) == 0) begin
        drain_results();
      end
    end
  endtask

  task automatic check_field(input string name, input cnt_t expected, input cnt_t actual);
    if (expected !== actual) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, expected,
               actual);
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    access_result_t exp_res;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual hit=%b evict=%b", $realtime,
                 out_was_hit, out_was_eviction);
      end else begin
        exp_res = pending_results.pop_front();
        check_field("was_hit", cnt_t'(exp_res.was_hit), cnt_t'(out_was_hit));
        check_field("was_eviction", cnt_t'(exp_res.was_eviction), cnt_t'(out_was_eviction));
        check_field("repeat_hit", cnt_t'(exp_res.repeat_hit), cnt_t'(out_repeat_hit));
        check_field("hit_total", exp_res.hit_total, out_hit_total);
        check_field("miss_total", exp_res.miss_total, out_miss_total);
        check_field("eviction_total", exp_res.eviction_total, out_eviction_total);
      end
    end
  end

  // Stop the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (line_present[i]) begin
      line_present[i]  = 1'b0;
      line_tag_copy[i] = '0;
      line_use_time[i] = '0;
    end
    use_clock      = '0;
    shadow_hits    = '0;
    shadow_misses  = '0;
    evict_count    = '0;
    offset_setting = OFFSET_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_fill_and_evict();
    test_offset_extremes();
    test_random_traffic(4'd0, 0, 90);
    test_random_traffic(4'd12, 50, 90);
    test_random_traffic(4'd15, 23, 90);
    test_random_traffic(4'd1, 0, 90);
    test_random_traffic(4'd7, 50, 90);
    test_random_traffic(4'd4, 23, 100);
    drain_results();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/salc_pkg.sv
hdl/set_assoc_lru_cache_model.sv
sim/tb_set_assoc_lru_cache_model.sv
